// ----- sv/q4sg_pkg.sv -----
// Shared types and constants for the Q4 shape and gradient core.
`timescale 1ns / 1ps
package q4sg_pkg;

   localparam int NODES = 4;
   localparam logic [1:0] LAST_NODE = 2'd3;

   typedef struct packed {
      logic signed [15:0] xi;
      logic signed [15:0] eta;
      logic signed [31:0] corner0_x;
      logic signed [31:0] corner0_y;
      logic signed [31:0] corner1_x;
      logic signed [31:0] corner1_y;
      logic signed [31:0] corner2_x;
      logic signed [31:0] corner2_y;
      logic signed [31:0] corner3_x;
      logic signed [31:0] corner3_y;
   } q4sg_req_type;

   typedef struct packed {
      logic [1:0]         node_index;
      logic [14:0]        shape_value;
      logic signed [31:0] grad_x;
      logic signed [31:0] grad_y;
      logic               singular;
      logic               last_node;
   } q4sg_rsp_type;

endpackage

// ----- sv/q4sg_channels.sv -----
// Valid/ready channel interfaces for request and response words.
`timescale 1ns / 1ps
interface q4sg_req_if;
   import q4sg_pkg::*;
   logic         valid;
   logic         ready;
   q4sg_req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface q4sg_rsp_if;
   import q4sg_pkg::*;
   logic         valid;
   logic         ready;
   q4sg_rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/quad4_shape_and_gradients_core.sv -----
// Q4 shape functions, Jacobian inversion and physical gradients, fully pipelined.
//
//   channel  dir  word                             handshake
//   req_bus  in   xi, eta, four corner x/y         valid/ready
//   rsp_bus  out  one node result, four per item   valid/ready
//
// Five item stages build shapes, Jacobian and determinant; a node sequencer then
// issues one node per cycle when not stalled, through two numerator stages, a
// magnitude stage and a 32-stage restoring divider (x and y lanes).
// Sustained item rate is set by the sequencer and the single result port, which
// carry four node words per item.
// Synchronous reset clears valid bits and the node counter only.
// Each stage advances when empty or when the next one advances (F only on its
// last node), so a stall holds every word in place and bubbles collapse.
`timescale 1ns / 1ps
module quad4_shape_and_gradients_core (
   input logic       clock,
   input logic       reset,
   q4sg_req_if.sink  req_bus,
   q4sg_rsp_if.source rsp_bus
);
   import q4sg_pkg::*;

   localparam int DIV_STAGES = 32;

   typedef struct packed {
      logic [65:0] rem;
      logic [31:0] q;
   } lane_type;

   typedef struct packed {
      logic [63:0] ud;
      lane_type    lx;
      lane_type    ly;
      logic        negx;
      logic        negy;
      logic        sing;
      logic [1:0]  node;
      logic [14:0] shp;
   } dv_type;

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      if (v > 36'sd2147483647) return 32'sh7fffffff;
      if (v < -36'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic lane_type div_step(input lane_type l, input logic [63:0] ud,
                                         input logic [4:0] sh);
      logic [95:0] dsh;
      logic [95:0] r;
      lane_type    o;
      dsh = {32'b0, ud} << sh;
      r = {30'b0, l.rem};
      o = l;
      if (r >= dsh) begin
         o.rem = 66'(r - dsh);
         o.q[sh] = 1'b1;
      end
      return o;
   endfunction

   // handshake enables
   logic en_a, en_b, en_c, en_d, en_e, f_take, en_g, en_h, en_o;
   logic den [0:DIV_STAGES+1];

   // stage A
   q4sg_req_type a_ff;
   logic a_v_ff;

   // stage B
   logic signed [16:0] dxi_in [NODES];
   logic signed [16:0] deta_in [NODES];
   logic signed [31:0] cx [NODES];
   logic signed [31:0] cy [NODES];
   logic signed [48:0] m00_in [NODES], m01_in [NODES], m10_in [NODES], m11_in [NODES];
   logic signed [33:0] sr_in [NODES];
   logic signed [48:0] b_m00_ff [NODES], b_m01_ff [NODES], b_m10_ff [NODES];
   logic signed [48:0] b_m11_ff [NODES];
   logic signed [33:0] b_sr_ff [NODES];
   logic signed [16:0] b_dxi_ff [NODES], b_deta_ff [NODES];
   logic b_v_ff;

   // stage C
   logic signed [51:0] s00, s01, s10, s11;
   logic signed [34:0] st;
   logic signed [34:0] sv;
   logic signed [31:0] j00_in, j01_in, j10_in, j11_in;
   logic [14:0] shp_in [NODES];
   logic signed [31:0] c_j00_ff, c_j01_ff, c_j10_ff, c_j11_ff;
   logic [14:0] c_shp_ff [NODES];
   logic signed [16:0] c_dxi_ff [NODES], c_deta_ff [NODES];
   logic c_v_ff;

   // stage D
   logic signed [63:0] d_p0_ff, d_p1_ff;
   logic signed [31:0] d_j00_ff, d_j01_ff, d_j10_ff, d_j11_ff;
   logic [14:0] d_shp_ff [NODES];
   logic signed [16:0] d_dxi_ff [NODES], d_deta_ff [NODES];
   logic d_v_ff;

   // stage E
   logic signed [64:0] e_det_ff;
   logic signed [31:0] e_j00_ff, e_j01_ff, e_j10_ff, e_j11_ff;
   logic [14:0] e_shp_ff [NODES];
   logic signed [16:0] e_dxi_ff [NODES], e_deta_ff [NODES];
   logic e_v_ff;

   // stage F, node sequencer
   logic signed [64:0] f_det_ff;
   logic signed [31:0] f_j00_ff, f_j01_ff, f_j10_ff, f_j11_ff;
   logic [14:0] f_shp_ff [NODES];
   logic signed [16:0] f_dxi_ff [NODES], f_deta_ff [NODES];
   logic [1:0] f_node_ff;
   logic f_v_ff;

   // stage G
   logic signed [16:0] g_dx, g_de;
   logic signed [48:0] g_xa_ff, g_xb_ff, g_ya_ff, g_yb_ff;
   logic signed [64:0] g_det_ff;
   logic [14:0] g_shp_ff;
   logic [1:0] g_node_ff;
   logic g_v_ff;

   // stage H
   logic signed [49:0] h_nx_ff, h_ny_ff;
   logic signed [64:0] h_det_ff;
   logic [14:0] h_shp_ff;
   logic [1:0] h_node_ff;
   logic h_v_ff;

   // divider
   dv_type dv_in [0:DIV_STAGES];
   dv_type dv_ff [0:DIV_STAGES];
   logic dv_v_ff [0:DIV_STAGES];
   logic [49:0] ux, uy;
   logic [64:0] udet;

   // output
   q4sg_rsp_type o_in, o_ff;
   logic o_v_ff;
   logic [31:0] mx, my;

   assign en_o = !o_v_ff || rsp_bus.ready;
   always_comb begin
      den[DIV_STAGES+1] = en_o;
      for (int s = DIV_STAGES; s >= 0; s--) begin
         den[s] = !dv_v_ff[s] || den[s+1];
      end
   end
   assign en_h = !h_v_ff || den[0];
   assign en_g = !g_v_ff || en_h;
   assign f_take = !f_v_ff || ((f_node_ff == LAST_NODE) && en_g);
   assign en_e = !e_v_ff || f_take;
   assign en_d = !d_v_ff || en_e;
   assign en_c = !c_v_ff || en_d;
   assign en_b = !b_v_ff || en_c;
   assign en_a = !a_v_ff || en_b;
   assign req_bus.ready = en_a;

   // A: capture word
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (en_a) begin
         a_v_ff <= req_bus.valid;
      end
      if (en_a) a_ff <= req_bus.payload;
   end

   // B: natural derivatives and products
   always_comb begin
      logic signed [16:0] xe, ee;
      xe = 17'(a_ff.xi);
      ee = 17'(a_ff.eta);
      dxi_in[0] = ee - 17'sd16384;
      dxi_in[1] = 17'sd16384 - ee;
      dxi_in[2] = ee + 17'sd16384;
      dxi_in[3] = 17'sd0 - dxi_in[2];
      deta_in[0] = xe - 17'sd16384;
      deta_in[2] = xe + 17'sd16384;
      deta_in[1] = 17'sd0 - deta_in[2];
      deta_in[3] = 17'sd16384 - xe;
      cx[0] = a_ff.corner0_x; cy[0] = a_ff.corner0_y;
      cx[1] = a_ff.corner1_x; cy[1] = a_ff.corner1_y;
      cx[2] = a_ff.corner2_x; cy[2] = a_ff.corner2_y;
      cx[3] = a_ff.corner3_x; cy[3] = a_ff.corner3_y;
      for (int k = 0; k < NODES; k++) begin
         m00_in[k] = 49'(dxi_in[k]) * 49'(cx[k]);
         m01_in[k] = 49'(dxi_in[k]) * 49'(cy[k]);
         m10_in[k] = 49'(deta_in[k]) * 49'(cx[k]);
         m11_in[k] = 49'(deta_in[k]) * 49'(cy[k]);
      end
      sr_in[0] = 34'(deta_in[0]) * 34'(dxi_in[0]);
      sr_in[1] = 34'(deta_in[1]) * 34'(dxi_in[0]);
      sr_in[2] = 34'(deta_in[2]) * 34'(dxi_in[2]);
      sr_in[3] = 34'(deta_in[3]) * 34'(dxi_in[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (en_b) begin
         b_v_ff <= a_v_ff;
      end
      if (en_b) begin
         b_m00_ff <= m00_in;
         b_m01_ff <= m01_in;
         b_m10_ff <= m10_in;
         b_m11_ff <= m11_in;
         b_sr_ff <= sr_in;
         b_dxi_ff <= dxi_in;
         b_deta_ff <= deta_in;
      end
   end

   // C: Jacobian sums and shape rounding
   always_comb begin
      s00 = 52'sd32768;
      s01 = 52'sd32768;
      s10 = 52'sd32768;
      s11 = 52'sd32768;
      for (int k = 0; k < NODES; k++) begin
         s00 = s00 + 52'(b_m00_ff[k]);
         s01 = s01 + 52'(b_m01_ff[k]);
         s10 = s10 + 52'(b_m10_ff[k]);
         s11 = s11 + 52'(b_m11_ff[k]);
      end
      j00_in = sat32(36'(s00 >>> 16));
      j01_in = sat32(36'(s01 >>> 16));
      j10_in = sat32(36'(s10 >>> 16));
      j11_in = sat32(36'(s11 >>> 16));
      st = '0;
      sv = '0;
      for (int k = 0; k < NODES; k++) begin
         st = 35'(b_sr_ff[k]) + 35'sd32768;
         sv = st >>> 16;
         if (sv < 35'sd0) shp_in[k] = 15'd0;
         else if (sv > 35'sd16384) shp_in[k] = 15'd16384;
         else shp_in[k] = sv[14:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (en_c) begin
         c_v_ff <= b_v_ff;
      end
      if (en_c) begin
         c_j00_ff <= j00_in;
         c_j01_ff <= j01_in;
         c_j10_ff <= j10_in;
         c_j11_ff <= j11_in;
         c_shp_ff <= shp_in;
         c_dxi_ff <= b_dxi_ff;
         c_deta_ff <= b_deta_ff;
      end
   end

   // D: determinant products
   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
      end else if (en_d) begin
         d_v_ff <= c_v_ff;
      end
      if (en_d) begin
         d_p0_ff <= 64'(c_j00_ff) * 64'(c_j11_ff);
         d_p1_ff <= 64'(c_j01_ff) * 64'(c_j10_ff);
         d_j00_ff <= c_j00_ff;
         d_j01_ff <= c_j01_ff;
         d_j10_ff <= c_j10_ff;
         d_j11_ff <= c_j11_ff;
         d_shp_ff <= c_shp_ff;
         d_dxi_ff <= c_dxi_ff;
         d_deta_ff <= c_deta_ff;
      end
   end

   // E: determinant
   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (en_e) begin
         e_v_ff <= d_v_ff;
      end
      if (en_e) begin
         e_det_ff <= 65'(d_p0_ff) - 65'(d_p1_ff);
         e_j00_ff <= d_j00_ff;
         e_j01_ff <= d_j01_ff;
         e_j10_ff <= d_j10_ff;
         e_j11_ff <= d_j11_ff;
         e_shp_ff <= d_shp_ff;
         e_dxi_ff <= d_dxi_ff;
         e_deta_ff <= d_deta_ff;
      end
   end

   // F: hold item, advance one node per cycle while stage G advances
   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
         f_node_ff <= '0;
      end else if (f_take) begin
         f_v_ff <= e_v_ff;
         f_node_ff <= '0;
      end else if (en_g) begin
         f_node_ff <= f_node_ff + 2'd1;
      end
      if (f_take) begin
         f_det_ff <= e_det_ff;
         f_j00_ff <= e_j00_ff;
         f_j01_ff <= e_j01_ff;
         f_j10_ff <= e_j10_ff;
         f_j11_ff <= e_j11_ff;
         f_shp_ff <= e_shp_ff;
         f_dxi_ff <= e_dxi_ff;
         f_deta_ff <= e_deta_ff;
      end
   end

   // G: numerator products
   assign g_dx = f_dxi_ff[f_node_ff];
   assign g_de = f_deta_ff[f_node_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         g_v_ff <= 1'b0;
      end else if (en_g) begin
         g_v_ff <= f_v_ff;
      end
      if (en_g) begin
         g_xa_ff <= 49'(f_j11_ff) * 49'(g_dx);
         g_xb_ff <= 49'(f_j01_ff) * 49'(g_de);
         g_ya_ff <= 49'(f_j00_ff) * 49'(g_de);
         g_yb_ff <= 49'(f_j10_ff) * 49'(g_dx);
         g_det_ff <= f_det_ff;
         g_shp_ff <= f_shp_ff[f_node_ff];
         g_node_ff <= f_node_ff;
      end
   end

   // H: numerators
   always_ff @(posedge clock) begin
      if (reset) begin
         h_v_ff <= 1'b0;
      end else if (en_h) begin
         h_v_ff <= g_v_ff;
      end
      if (en_h) begin
         h_nx_ff <= 50'(g_xa_ff) - 50'(g_xb_ff);
         h_ny_ff <= 50'(g_ya_ff) - 50'(g_yb_ff);
         h_det_ff <= g_det_ff;
         h_shp_ff <= g_shp_ff;
         h_node_ff <= g_node_ff;
      end
   end

   // divider: stage 0 takes magnitudes, stage s resolves quotient bit 32-s
   always_comb begin
      ux = h_nx_ff[49] ? 50'(-h_nx_ff) : 50'(h_nx_ff);
      uy = h_ny_ff[49] ? 50'(-h_ny_ff) : 50'(h_ny_ff);
      udet = h_det_ff[64] ? 65'(-h_det_ff) : 65'(h_det_ff);
      dv_in[0].ud = udet[63:0];
      dv_in[0].lx.rem = {ux, 16'b0};
      dv_in[0].lx.q = '0;
      dv_in[0].ly.rem = {uy, 16'b0};
      dv_in[0].ly.q = '0;
      dv_in[0].negx = h_nx_ff[49] ^ h_det_ff[64];
      dv_in[0].negy = h_ny_ff[49] ^ h_det_ff[64];
      dv_in[0].sing = (h_det_ff == 65'sd0);
      dv_in[0].node = h_node_ff;
      dv_in[0].shp = h_shp_ff;
      for (int s = 1; s <= DIV_STAGES; s++) begin
         dv_in[s] = dv_ff[s-1];
         dv_in[s].lx = div_step(dv_ff[s-1].lx, dv_ff[s-1].ud, 5'(DIV_STAGES - s));
         dv_in[s].ly = div_step(dv_ff[s-1].ly, dv_ff[s-1].ud, 5'(DIV_STAGES - s));
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= DIV_STAGES; s++) begin
         if (reset) begin
            dv_v_ff[s] <= 1'b0;
         end else if (den[s]) begin
            dv_v_ff[s] <= (s == 0) ? h_v_ff : dv_v_ff[(s == 0) ? 0 : s - 1];
         end
         if (den[s]) dv_ff[s] <= dv_in[s];
      end
   end

   // output: sign, saturate, zero on singular
   always_comb begin
      mx = {1'b0, dv_ff[DIV_STAGES].lx.q[30:0]};
      my = {1'b0, dv_ff[DIV_STAGES].ly.q[30:0]};
      o_in.node_index = dv_ff[DIV_STAGES].node;
      o_in.shape_value = dv_ff[DIV_STAGES].shp;
      o_in.singular = dv_ff[DIV_STAGES].sing;
      o_in.last_node = (dv_ff[DIV_STAGES].node == LAST_NODE);
      if (dv_ff[DIV_STAGES].sing) begin
         o_in.grad_x = '0;
         o_in.grad_y = '0;
      end else begin
         if (dv_ff[DIV_STAGES].lx.q[31])
            o_in.grad_x = dv_ff[DIV_STAGES].negx ? 32'sh80000000 : 32'sh7fffffff;
         else
            o_in.grad_x = dv_ff[DIV_STAGES].negx ? 32'(-mx) : mx;
         if (dv_ff[DIV_STAGES].ly.q[31])
            o_in.grad_y = dv_ff[DIV_STAGES].negy ? 32'sh80000000 : 32'sh7fffffff;
         else
            o_in.grad_y = dv_ff[DIV_STAGES].negy ? 32'(-my) : my;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else if (en_o) begin
         o_v_ff <= dv_v_ff[DIV_STAGES];
      end
      if (en_o) o_ff <= o_in;
   end

   assign rsp_bus.valid = o_v_ff;
   assign rsp_bus.payload = o_ff;

   a_node_seq: assert property (@(posedge clock) disable iff (reset)
      (f_v_ff && en_g && !f_take) |=> (f_node_ff == $past(f_node_ff) + 2'd1))
      else $error("node sequence skipped or repeated");

   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      (o_v_ff && o_ff.singular) |-> (o_ff.grad_x == 32'sd0 && o_ff.grad_y == 32'sd0))
      else $error("singular word carries nonzero gradient");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (dv_v_ff[DIV_STAGES] && !dv_ff[DIV_STAGES].sing) |-> (dv_ff[DIV_STAGES].ud != 64'd0))
      else $error("nonsingular word with zero divisor");

endmodule

// ----- tb/quad4_shape_and_gradients_core_tb.sv -----
// Self-checking testbench for the Q4 shape and gradient core.
`timescale 1ns / 1ps
module quad4_shape_and_gradients_core_tb;
   import q4sg_pkg::*;

   localparam int ONE = 16384;
   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;

   q4sg_req_if req_bus ();
   q4sg_rsp_if rsp_bus ();

   quad4_shape_and_gradients_core u_top (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   typedef struct {
      q4sg_req_type req;
      bit           fixed;
      q4sg_rsp_type rsp [4];
   } stim_row_type;

   q4sg_rsp_type node_results_q [$];
   q4sg_req_type items_q [$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit timed_out = 0;
   bit hold_off = 0;
   bit stim_done = 0;

   function automatic longint floor_shift16(longint v);
      return v >>> 16;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint gradient_quotient(longint num, longint den);
      bit neg;
      longint unsigned un, ud, q, r, frac;
      neg = (num < 0) != (den < 0);
      un = (num < 0) ? -num : num;
      ud = (den < 0) ? -den : den;
      q = un / ud;
      r = un % ud;
      frac = 0;
      if (q >= 32768) return neg ? -64'sd2147483648 : 64'sd2147483647;
      for (int i = 0; i < 16; i++) begin
         r = r << 1;
         frac = frac << 1;
         if (r >= ud) begin
            r = r - ud;
            frac = frac | 1;
         end
      end
      return neg ? -longint'((q << 16) | frac) : longint'((q << 16) | frac);
   endfunction

   task automatic predict_nodes(input q4sg_req_type r);
      longint xi, eta, v, det, gx, gy;
      longint cx [4], cy [4], dxi [4], deta [4], shp [4];
      longint s00, s01, s10, s11, j00, j01, j10, j11;
      q4sg_rsp_type o;
      xi = longint'(r.xi);
      eta = longint'(r.eta);
      cx[0] = longint'(r.corner0_x); cy[0] = longint'(r.corner0_y);
      cx[1] = longint'(r.corner1_x); cy[1] = longint'(r.corner1_y);
      cx[2] = longint'(r.corner2_x); cy[2] = longint'(r.corner2_y);
      cx[3] = longint'(r.corner3_x); cy[3] = longint'(r.corner3_y);
      dxi[0] = eta - ONE;  dxi[1] = ONE - eta;
      dxi[2] = eta + ONE;  dxi[3] = -(eta + ONE);
      deta[0] = xi - ONE;  deta[1] = -(xi + ONE);
      deta[2] = xi + ONE;  deta[3] = ONE - xi;
      shp[0] = (xi - ONE) * (eta - ONE);
      shp[1] = -(xi + ONE) * (eta - ONE);
      shp[2] = (xi + ONE) * (eta + ONE);
      shp[3] = -(xi - ONE) * (eta + ONE);
      s00 = 0; s01 = 0; s10 = 0; s11 = 0;
      for (int k = 0; k < NODES; k++) begin
         v = floor_shift16(shp[k] + 32768);
         if (v < 0) v = 0;
         if (v > ONE) v = ONE;
         shp[k] = v;
         s00 += dxi[k] * cx[k];
         s01 += dxi[k] * cy[k];
         s10 += deta[k] * cx[k];
         s11 += deta[k] * cy[k];
      end
      j00 = clamp32(floor_shift16(s00 + 32768));
      j01 = clamp32(floor_shift16(s01 + 32768));
      j10 = clamp32(floor_shift16(s10 + 32768));
      j11 = clamp32(floor_shift16(s11 + 32768));
      det = j00 * j11 - j01 * j10;
      for (int k = 0; k < NODES; k++) begin
         gx = 0;
         gy = 0;
         if (det != 0) begin
            gx = gradient_quotient(j11 * dxi[k] - j01 * deta[k], det);
            gy = gradient_quotient(j00 * deta[k] - j10 * dxi[k], det);
         end
         o.node_index = k[1:0];
         o.shape_value = shp[k][14:0];
         o.grad_x = gx[31:0];
         o.grad_y = gy[31:0];
         o.singular = (det == 0);
         o.last_node = (k == NODES - 1);
         node_results_q.push_back(o);
      end
   endtask

   function automatic q4sg_req_type make_item(int xi, int eta, int x0, int y0, int x1,
                                              int y1, int x2, int y2, int x3, int y3);
      q4sg_req_type r;
      r.xi = 16'(xi); r.eta = 16'(eta);
      r.corner0_x = x0; r.corner0_y = y0; r.corner1_x = x1; r.corner1_y = y1;
      r.corner2_x = x2; r.corner2_y = y2; r.corner3_x = x3; r.corner3_y = y3;
      return r;
   endfunction

   function automatic q4sg_rsp_type node_word(int k, int shp, int gx, int gy, bit sing);
      q4sg_rsp_type o;
      o.node_index = k[1:0];
      o.shape_value = shp[14:0];
      o.grad_x = gx;
      o.grad_y = gy;
      o.singular = sing;
      o.last_node = (k == 3);
      return o;
   endfunction

   function automatic int rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 8) * 32'sh10000 - 32'sh40000;
         default: return int'($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
      endcase
   endfunction

   function automatic int rand_nat();
      case ($urandom_range(0, 7))
         0: return int'($urandom & 16'hFFFF) - 32768;
         1: return ($urandom_range(0, 1) ? ONE : -ONE);
         default: return int'($urandom_range(0, 2 * ONE)) - ONE;
      endcase
   endfunction

   function automatic q4sg_req_type random_item();
      int sx, sy, ox, oy;
      if ($urandom_range(0, 9) < 7) begin
         sx = $urandom_range(1, 16) << 14;
         sy = $urandom_range(1, 16) << 14;
         ox = rand_coord();
         oy = rand_coord();
         return make_item(rand_nat(), rand_nat(),
            ox - sx + int'($urandom_range(0, 8191)), oy - sy,
            ox + sx, oy - sy + int'($urandom_range(0, 8191)),
            ox + sx, oy + sy, ox - sx, oy + sy - int'($urandom_range(0, 8191)));
      end
      return make_item(rand_nat(), rand_nat(), rand_coord(), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord());
   endfunction

   stim_row_type directed [$];

   initial begin
      stim_row_type row;
      q4sg_req_type unit_sq;
      int wait_n;
      unit_sq = make_item(0, 0, -32'sh10000, -32'sh10000, 32'sh10000, -32'sh10000,
                          32'sh10000, 32'sh10000, -32'sh10000, 32'sh10000);
      row.fixed = 1;
      row.req = unit_sq;
      row.rsp[0] = node_word(0, 4096, -32'sh4000, -32'sh4000, 0);
      row.rsp[1] = node_word(1, 4096, 32'sh4000, -32'sh4000, 0);
      row.rsp[2] = node_word(2, 4096, 32'sh4000, 32'sh4000, 0);
      row.rsp[3] = node_word(3, 4096, -32'sh4000, 32'sh4000, 0);
      directed.push_back(row);
      row.req = make_item(ONE, -ONE, 0, 0, 0, 0, 0, 0, 0, 0);
      row.rsp[0] = node_word(0, 0, 0, 0, 1);
      row.rsp[1] = node_word(1, ONE, 0, 0, 1);
      row.rsp[2] = node_word(2, 0, 0, 0, 1);
      row.rsp[3] = node_word(3, 0, 0, 0, 1);
      directed.push_back(row);
      row.req = make_item(-ONE, -ONE, 5, 5, 5, 5, 5, 5, 5, 5);
      row.rsp[0] = node_word(0, ONE, 0, 0, 1);
      row.rsp[1] = node_word(1, 0, 0, 0, 1);
      row.rsp[2] = node_word(2, 0, 0, 0, 1);
      row.rsp[3] = node_word(3, 0, 0, 0, 1);
      directed.push_back(row);
      row.fixed = 0;
      row.req = unit_sq; row.req.xi = 16'(ONE); row.req.eta = 16'(ONE);
      directed.push_back(row);
      row.req = unit_sq; row.req.xi = 16'sh8000; row.req.eta = 16'sh7fff;
      directed.push_back(row);
      row.req = unit_sq; row.req.xi = 16'sh7fff; row.req.eta = 16'sh8000;
      directed.push_back(row);
      row.req = unit_sq; row.req.xi = -16'sd1; row.req.eta = 16'sd1;
      directed.push_back(row);
      row.req = make_item(0, 0, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                          32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      directed.push_back(row);
      row.req = make_item(100, -200, 32'h7FFFFFFF, 0, 32'h80000000, 1, 32'h7FFFFFFF,
                          32'h80000000, 0, 32'h7FFFFFFF);
      directed.push_back(row);
      row.req = make_item(0, 0, 0, 0, 1, 0, 1, 1, 0, 1);
      directed.push_back(row);
      row.req = make_item(0, 0, 0, 0, 32'h7FFFFFFF, 0, 32'h7FFFFFFF, 2, 0, 2);
      directed.push_back(row);
      row.req = make_item(0, 0, 0, 0, 32'sh10000, 0, 32'sh20000, 0, 32'sh30000, 0);
      directed.push_back(row);
      row.req = make_item(8192, -8192, -1, -1, -1, -1, -1, -1, -1, -1);
      directed.push_back(row);
      row.req = make_item(-16384, 16384, 32'hFFFFFFFF, 32'hAAAAAAAA, 32'h55555555,
                          32'h0F0F0F0F, 32'hF0F0F0F0, 32'h12345678, 32'hEDCBA987, 0);
      directed.push_back(row);

      req_bus.valid <= 1'b0;
      req_bus.payload <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         if (directed[i].fixed) begin
            for (int k = 0; k < 4; k++) node_results_q.push_back(directed[i].rsp[k]);
         end else begin
            predict_nodes(directed[i].req);
         end
         items_q.push_back(directed[i].req);
      end
      for (int i = 0; i < 146; i++) begin
         items_q.push_back(random_item());
         predict_nodes(items_q[$]);
      end

      while (items_q.size() > 0) begin
         wait_n = (items_q.size() > 60 && items_q.size() < 120) ? 0 : $urandom_range(0, 3);
         if (wait_n > 0) begin
            req_bus.valid <= 1'b0;
            repeat (wait_n) @(posedge clock);
         end
         req_bus.valid <= 1'b1;
         req_bus.payload <= items_q[0];
         @(posedge clock);
         while (!req_bus.ready) @(posedge clock);
         void'(items_q.pop_front());
      end
      req_bus.valid <= 1'b0;
      stim_done = 1;
   end

   initial begin
      int wait_n;
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      forever begin
         wait_n = $urandom_range(0, 3);
         if ($urandom_range(0, 3) == 0) wait_n = 0;
         if (wait_n > 0 || hold_off) begin
            rsp_bus.ready <= 1'b0;
            repeat (wait_n) @(posedge clock);
            while (hold_off) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   initial begin
      @(negedge reset);
      repeat (300) @(posedge clock);
      hold_off = 1;
      repeat (400) @(posedge clock);
      hold_off = 0;
   end

   always @(posedge clock) begin
      q4sg_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (node_results_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected node word %p", rsp_bus.payload);
         end else begin
            want = node_results_q.pop_front();
            if (rsp_bus.payload !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", want, rsp_bus.payload);
            end
         end
      end
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      @(negedge reset);
      fork
         begin
            wait (stim_done && node_results_q.size() == 0);
            repeat (DRAIN_CYCLES) @(posedge clock);
         end
         begin
            wait (idle_cycles >= IDLE_LIMIT);
            timed_out = 1;
         end
      join_any
      if (!timed_out && mismatches == 0 && node_results_q.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/q4sg_pkg.sv
sv/q4sg_channels.sv
sv/quad4_shape_and_gradients_core.sv
tb/quad4_shape_and_gradients_core_tb.sv
